// File: sv/ilid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants of the positional insert/delete list.
// ----------------------------------------------------------------------------
package ilid_pkg;

   // list storage geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = 7;
   localparam int DATA_W   = 32;

   // operation codes carried by req_mode
   typedef enum logic [2:0] {
      MODE_READ   = 3'd0,
      MODE_HEAD   = 3'd1,
      MODE_TAIL   = 3'd2,
      MODE_AT     = 3'd3,
      MODE_DELETE = 3'd4
   } mode_type;

   // status codes carried by rsp_status
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_FETCH  = 8'b0000_0010,
      S_CATCH  = 8'b0000_0100,
      S_INS_RD = 8'b0000_1000,
      S_INS_WR = 8'b0001_0000,
      S_PUT    = 8'b0010_0000,
      S_DEL_RD = 8'b0100_0000,
      S_DEL_WR = 8'b1000_0000
   } state_type;

   // list length and RAM address types
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

endpackage

// File: sv/indexed_list_insert_delete_core.sv
`timescale 1ns / 1ps
// Read passes S_FETCH and S_CATCH; insert moves each entry at or after the position
// up, then writes the new value in S_PUT; delete moves each later entry down, or
// answers at once on the last entry, as do out-of-range, full and unused modes.
// The response is held until rsp_ready. One transaction at a time, accepted again
// the cycle after the response is taken; a shifted entry takes a RAM read and write.
// Reset (synchronous, active high) empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of signed 32-bit values with read, insert at head/tail/position
// and delete at position. Later entries are moved one RAM word per step.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_mode,
   input  logic [6:0]                    req_position,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_read_data,
   output logic [1:0]                    rsp_status,
   output logic [ilid_pkg::COUNT_W-1:0]  rsp_length
);
   import ilid_pkg::*;

   state_type             state_ff, state_in;
   logic                  pend_ff, pend_in;
   count_type             count_ff, count_in;
   addr_type              ptr_ff, ptr_in;
   addr_type              target_ff, target_in;
   logic [DATA_W-1:0]     value_ff, value_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   status_type            status_ff, status_in;

   logic [DATA_W-1:0]     entry_mem [CAPACITY];
   logic [DATA_W-1:0]     rd_data_ff;
   addr_type              rd_addr;
   addr_type              wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic                  wr_en;
   logic                  accept;
   logic                  full;
   count_type             ptr_ext;

   assign req_ready     = (state_ff == S_IDLE) && !pend_ff;
   assign rsp_valid     = pend_ff;
   assign rsp_read_data = data_ff;
   assign rsp_status    = status_ff;
   assign rsp_length    = count_ff;

   assign accept  = req_valid && req_ready;
   assign full    = (count_ff == COUNT_W'(CAPACITY));
   assign ptr_ext = {1'b0, ptr_ff};

   // shared address unit: current pointer, or its neighbor while moving entries
   always_comb begin
      priority case (1'b1)
         state_ff[3]: rd_addr = ptr_ff - 1'b1;
         state_ff[6]: rd_addr = ptr_ff + 1'b1;
         default:     rd_addr = ptr_ff;
      endcase
   end

   // write port: moved word, or the new value
   always_comb begin
      wr_en   = (state_ff == S_INS_WR) || (state_ff == S_DEL_WR) || (state_ff == S_PUT);
      wr_addr = (state_ff == S_PUT) ? target_ff : ptr_ff;
      wr_data = (state_ff == S_PUT) ? value_ff : rd_data_ff;
   end

   // list RAM, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      target_in = target_ff;
      value_in  = value_ff;
      data_in   = data_ff;
      status_in = status_ff;

      // drop the response once taken
      if (pend_ff && rsp_ready) begin
         pend_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in   = '0;
               status_in = ST_DONE;
               value_in  = req_value;
               unique case (req_mode)
                  MODE_READ: begin
                     if (COUNT_W'(req_position) < count_ff) begin
                        ptr_in   = req_position[ADDR_W-1:0];
                        state_in = S_FETCH;
                     end else begin
                        data_in   = '1;
                        status_in = ST_RANGE;
                        pend_in   = 1'b1;
                     end
                  end
                  MODE_HEAD, MODE_TAIL, MODE_AT: begin
                     if ((req_mode == MODE_AT) && (COUNT_W'(req_position) > count_ff)) begin
                        status_in = ST_RANGE;
                        pend_in   = 1'b1;
                     end else if (full) begin
                        status_in = ST_FULL;
                        pend_in   = 1'b1;
                     end else begin
                        ptr_in = count_ff[ADDR_W-1:0];
                        priority case (req_mode)
                           MODE_HEAD: target_in = '0;
                           MODE_TAIL: target_in = count_ff[ADDR_W-1:0];
                           default:   target_in = req_position[ADDR_W-1:0];
                        endcase
                        state_in = (count_ff[ADDR_W-1:0] == target_in) ? S_PUT : S_INS_RD;
                     end
                  end
                  MODE_DELETE: begin
                     if (COUNT_W'(req_position) < count_ff) begin
                        ptr_in = req_position[ADDR_W-1:0];
                        if ((COUNT_W'(req_position) + 1'b1) < count_ff) begin
                           state_in = S_DEL_RD;
                        end else begin
                           count_in = count_ff - 1'b1;
                           pend_in  = 1'b1;
                        end
                     end else begin
                        status_in = ST_RANGE;
                        pend_in   = 1'b1;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                     pend_in   = 1'b1;
                  end
               endcase
            end
         end
         // read address presented, wait for RAM word
         S_FETCH: state_in = S_CATCH;
         S_CATCH: begin
            data_in  = rd_data_ff;
            pend_in  = 1'b1;
            state_in = S_IDLE;
         end
         // move entry ptr-1 up to ptr
         S_INS_RD: state_in = S_INS_WR;
         S_INS_WR: begin
            ptr_in   = ptr_ff - 1'b1;
            state_in = ((ptr_ff - 1'b1) == target_ff) ? S_PUT : S_INS_RD;
         end
         // place the new value and grow the list
         S_PUT: begin
            count_in = count_ff + 1'b1;
            pend_in  = 1'b1;
            state_in = S_IDLE;
         end
         // move entry ptr+1 down to ptr
         S_DEL_RD: state_in = S_DEL_WR;
         S_DEL_WR: begin
            ptr_in = ptr_ff + 1'b1;
            if ((ptr_ext + COUNT_W'(2)) < count_ff) begin
               state_in = S_DEL_RD;
            end else begin
               count_in = count_ff - 1'b1;
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      target_ff <= target_in;
      value_ff  <= value_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

endmodule
